[rtl/core/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and codes for the address region permission check.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam int ADDR_W = 64;

  // request opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // flag bit positions, indexed directly by the permission kind
  localparam int FLAG_READ   = 0;
  localparam int FLAG_WRITE  = 1;
  localparam int FLAG_EXEC   = 2;
  localparam int FLAG_SHARED = 3;

  typedef logic [3:0] flags_t;

  // query token that walks the chain of region cells
  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        kind;
    logic              hit;
    logic              allowed;
  } token_t;

endpackage

`default_nettype wire

[rtl/core/arpc_cell.sv]
// ----------------------------------------------------------------------------
// arpc_cell
// One region slot: holds [start, end) and flags, checks a passing query token.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell
  import arpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire logic [ADDR_W-1:0] wr_start,
  input  wire logic [ADDR_W-1:0] wr_end,
  input  wire flags_t            wr_flags,
  input  wire token_t            tok_in,
  output token_t                 tok_out
);

  logic              valid;
  logic [ADDR_W-1:0] region_start;
  logic [ADDR_W-1:0] region_end;
  flags_t            flags;
  logic              match;

  // empty or inverted ranges never match
  assign match = valid && (tok_in.addr >= region_start) && (tok_in.addr < region_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      region_start <= wr_start;
      region_end   <= wr_end;
      flags        <= wr_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
      // first match in append order wins; later cells pass a hit through
      if (tok_in.active && !tok_in.hit && match) begin
        tok_out.hit     <= 1'b1;
        tok_out.allowed <= flags[tok_in.kind];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/address_region_permission_check.sv]
// ----------------------------------------------------------------------------
// address_region_permission_check
// Region table with first-match permission lookup, built as a cell chain.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An append stores the
// region in the next free cell and its result appears on the cycle after
// acceptance; busy stays low, so a request may follow every cycle. A query
// enters a token that steps through one region cell per clock, so its result
// passes the head register and then each cell register; busy is high until the
// cycle in which done pulses; the next request can be taken in that cycle.
// Results are shown for one cycle with done high and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module address_region_permission_check
  import arpc_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              opcode,
  input  wire logic [ADDR_W-1:0] region_start,
  input  wire logic [ADDR_W-1:0] region_end,
  input  wire logic              allow_read,
  input  wire logic              allow_write,
  input  wire logic              allow_execute,
  input  wire logic              mapping_shared,
  input  wire logic [ADDR_W-1:0] query_address,
  input  wire logic [1:0]        perm_kind,
  output logic                   done,
  output logic                   allowed,
  output logic                   region_hit,
  output logic                   status
);

  localparam int CW = $clog2(MAX_REGIONS + 1);

  logic          accept;
  logic          is_append;
  logic          table_full;
  logic [CW-1:0] region_count;
  flags_t        new_flags;
  token_t        tok_head;
  token_t        tok [MAX_REGIONS];

  assign accept     = start && !busy;
  assign is_append  = (opcode == OP_APPEND);
  assign table_full = (region_count == CW'(MAX_REGIONS));

  always_comb begin
    new_flags              = '0;
    new_flags[FLAG_READ]   = allow_read;
    new_flags[FLAG_WRITE]  = allow_write;
    new_flags[FLAG_EXEC]   = allow_execute;
    new_flags[FLAG_SHARED] = mapping_shared;
  end

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    token_t cell_in;

    if (i == 0) begin : g_first
      assign cell_in = tok_head;
    end else begin : g_next
      assign cell_in = tok[i-1];
    end

    arpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (accept && is_append && (region_count == CW'(i))),
      .wr_start (region_start),
      .wr_end   (region_end),
      .wr_flags (new_flags),
      .tok_in   (cell_in),
      .tok_out  (tok[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head     <= '0;
      busy         <= 1'b0;
      region_count <= '0;
      done         <= 1'b0;
      allowed      <= 1'b0;
      region_hit   <= 1'b0;
      status       <= STATUS_OK;
    end else begin
      tok_head.active  <= accept && !is_append;
      tok_head.addr    <= query_address;
      tok_head.kind    <= perm_kind;
      tok_head.hit     <= 1'b0;
      tok_head.allowed <= 1'b0;

      done       <= 1'b0;
      allowed    <= 1'b0;
      region_hit <= 1'b0;
      status     <= STATUS_OK;

      // query token leaving the last cell
      if (tok[MAX_REGIONS-1].active) begin
        done       <= 1'b1;
        allowed    <= tok[MAX_REGIONS-1].allowed;
        region_hit <= tok[MAX_REGIONS-1].hit;
        busy       <= 1'b0;
      end

      if (accept) begin
        if (is_append) begin
          done <= 1'b1;
          if (table_full) begin
            status <= STATUS_FULL;
          end else begin
            region_count <= region_count + CW'(1);
          end
        end else begin
          busy <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe while a query is in flight");

  a_query_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_append) |=> busy)
    else $error("query accepted without raising busy");

  a_miss_not_allowed: assert property (@(posedge clk) disable iff (rst)
    (done && !region_hit) |-> !allowed)
    else $error("allowed without a region hit");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FULL)) |-> (table_full && !region_hit))
    else $error("dropped append reported with free slots");
`endif

endmodule

`default_nettype wire
